[rtl/dhcv_pkg.sv]
// shared types and constants for the datagram header checksum validator
`default_nettype none

package dhcv_pkg;

	localparam int HEADER_BYTES         = 20;
	localparam int MAX_PACKET_BYTES_DEF = 65535;

	// header + 4 * sack + payload length tops out at 65615
	localparam int NEED_W    = 18;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CHECK  = 1'd1;

	typedef enum logic [2:0] {
		RSN_OK    = 3'd0,
		RSN_SHORT = 3'd1,
		RSN_ID    = 3'd2,
		RSN_CSUM  = 3'd3,
		RSN_LEN   = 3'd4
	} drop_reason_t;

	// one byte held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

endpackage

`default_nettype wire

[rtl/dhcv_if.sv]
// handshake channels: byte stream, verdict and register writes
`default_nettype none

interface dhcv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface dhcv_verdict_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [2:0] drop_reason;

	modport source (output valid, accepted, drop_reason, input ready);
	modport sink (input valid, accepted, drop_reason, output ready);
endinterface

interface dhcv_cfg_if;
	import dhcv_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/dhcv_in_stage.sv]
// input register that holds one byte until the checker takes it
`default_nettype none

module dhcv_in_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	dhcv_byte_if.sink            rx_bytes,
	input  wire                  advance,
	output dhcv_pkg::byte_item_t item_s1
);
	import dhcv_pkg::*;

	// room when empty or when the held byte moves on this cycle
	assign rx_bytes.ready = !item_s1.valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.valid     <= 1'b0;
			item_s1.data_byte <= '0;
			item_s1.last_byte <= 1'b0;
		end else if (rx_bytes.ready) begin
			item_s1.valid     <= rx_bytes.valid;
			item_s1.data_byte <= rx_bytes.data_byte;
			item_s1.last_byte <= rx_bytes.last_byte;
		end
	end

endmodule

`default_nettype wire

[rtl/dhcv_core.sv]
// per-datagram capture, ones-complement sum, checks and verdict register
`default_nettype none

module dhcv_core #(
	parameter int MAX_PACKET_BYTES = dhcv_pkg::MAX_PACKET_BYTES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dhcv_pkg::byte_item_t item_s1,
	output logic                 advance,
	dhcv_cfg_if.sink             cfg,
	dhcv_verdict_if.source       verdict
);
	import dhcv_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [31:0]      exp_id_q;
	logic             skip_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      sum_q;
	logic [7:0]       pend_q;
	logic [31:0]      conn_q;
	logic [3:0]       sack_q;
	logic [15:0]      plen_q;
	logic             out_valid_q;
	logic             accepted_q;
	drop_reason_t     reason_q;

	logic             live;
	logic             odd_idx;
	logic [15:0]      addend;
	logic [16:0]      raw_sum;
	logic [15:0]      sum_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic [7:0]       pend_nx;
	logic [31:0]      conn_nx;
	logic [3:0]       sack_nx;
	logic [15:0]      plen_nx;
	logic [NEED_W-1:0] need;
	drop_reason_t     reason_nx;
	logic [7:0]       b;

	assign cfg.ready = 1'b1;

	// a non-last byte never waits on the verdict side
	assign advance = item_s1.valid &&
		(!item_s1.last_byte || !out_valid_q || verdict.ready);

	assign b       = item_s1.data_byte;
	assign live    = cnt_q != CNT_W'(MAX_PACKET_BYTES);
	assign odd_idx = cnt_q[0];

	// word to fold in: full pair, or the zero-padded odd tail on the last byte
	always_comb begin
		if (live) begin
			if (odd_idx)
				addend = {pend_q, b};
			else if (item_s1.last_byte)
				addend = {b, 8'h00};
			else
				addend = 16'h0000;
		end else begin
			addend = (odd_idx && item_s1.last_byte) ? {pend_q, 8'h00} : 16'h0000;
		end
	end

	assign raw_sum = {1'b0, sum_q} + {1'b0, addend};
	assign sum_nx  = raw_sum[15:0] + 16'(raw_sum[16]);

	always_comb begin
		cnt_nx  = cnt_q;
		pend_nx = pend_q;
		conn_nx = conn_q;
		sack_nx = sack_q;
		plen_nx = plen_q;
		if (live) begin
			cnt_nx = cnt_q + CNT_W'(1);
			if (!odd_idx)
				pend_nx = b;
			if (cnt_q < CNT_W'(4))
				conn_nx = {conn_q[23:0], b};
			else if (cnt_q == CNT_W'(13))
				sack_nx = b[3:0];
			else if (cnt_q == CNT_W'(16))
				plen_nx = {b, plen_q[7:0]};
			else if (cnt_q == CNT_W'(17))
				plen_nx = {plen_q[15:8], b};
		end
	end

	assign need = NEED_W'(HEADER_BYTES) + NEED_W'({sack_nx, 2'b00}) + NEED_W'(plen_nx);

	always_comb begin
		priority if (NEED_W'(cnt_nx) < NEED_W'(HEADER_BYTES))
			reason_nx = RSN_SHORT;
		else if (!skip_q && conn_nx != exp_id_q)
			reason_nx = RSN_ID;
		else if (sum_nx != 16'hFFFF)
			reason_nx = RSN_CSUM;
		else if (NEED_W'(cnt_nx) < need)
			reason_nx = RSN_LEN;
		else
			reason_nx = RSN_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= '0;
			skip_q   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_EXPECTED_ID: exp_id_q <= cfg.data;
				CFG_SKIP_CHECK:  skip_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			pend_q <= '0;
			conn_q <= '0;
			sack_q <= '0;
			plen_q <= '0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				pend_q <= '0;
				conn_q <= '0;
				sack_q <= '0;
				plen_q <= '0;
			end else begin
				cnt_q  <= cnt_nx;
				sum_q  <= sum_nx;
				pend_q <= pend_nx;
				conn_q <= conn_nx;
				sack_q <= sack_nx;
				plen_q <= plen_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			reason_q    <= RSN_OK;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
			accepted_q  <= reason_nx == RSN_OK;
			reason_q    <= reason_nx;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign verdict.valid       = out_valid_q;
	assign verdict.accepted    = accepted_q;
	assign verdict.drop_reason = reason_q;

`ifndef NO_ASSERTIONS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> cnt_q == '0 && sum_q == '0)
		else $error("per-datagram state not cleared after last byte");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		NEED_W'(cnt_q) <= NEED_W'(MAX_PACKET_BYTES))
		else $error("byte count past saturation");

	a_accept_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> accepted_q == (reason_q == RSN_OK))
		else $error("accepted flag disagrees with drop reason");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready |=> out_valid_q && $stable(reason_q))
		else $error("pending verdict overwritten");
`endif

endmodule

`default_nettype wire

[rtl/datagram_header_checksum_validator_top.sv]
// top level of the datagram header checksum validator
//
//  channel   | dir | fields                    | request taken when
//  ----------+-----+---------------------------+--------------------
//  rx_bytes  | in  | data_byte[7:0], last_byte | valid & ready
//  verdict   | out | accepted, drop_reason[2:0]| valid & ready
//  cfg       | in  | index[0], data[31:0]      | valid & ready (ready tied high)
//
// one byte per cycle sustained unless a stalled verdict holds a last byte; a byte
// is registered, then the capture, sum fold and checks run in the next cycle and
// the verdict lands in a result register, valid once the checker takes the last
// byte; reset clears all per-datagram state and the registers (listening mode on)
// a stalled verdict holds back only a following last byte and the bytes behind it
`default_nettype none

module datagram_header_checksum_validator_top #(
	parameter int MAX_PACKET_BYTES = dhcv_pkg::MAX_PACKET_BYTES_DEF
) (
	input wire             clk,
	input wire             arst_n,
	dhcv_byte_if.sink      rx_bytes,
	dhcv_verdict_if.source verdict,
	dhcv_cfg_if.sink       cfg
);
	import dhcv_pkg::*;

	// byte held between the input register and the checker
	byte_item_t item_s1;
	// checker consumes the held byte this cycle
	logic       advance;

	dhcv_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_bytes (rx_bytes),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	// capture, running sum, checks and verdict register
	dhcv_core #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.cfg     (cfg),
		.verdict (verdict)
	);

endmodule

`default_nettype wire
